// ===== src/slps_pkg.sv =====
`timescale 1ns / 1ps
package slps_pkg;

  localparam int BATCH_SIZE = 8;
  localparam int TIME_WIDTH = 16;

  localparam int WORD_W = 16;
  localparam int CMP_W  = (TIME_WIDTH > WORD_W) ? TIME_WIDTH : WORD_W;
  localparam int IDX_W  = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
  localparam int MEM_DEPTH = 2 * BATCH_SIZE;
  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam logic [IDX_W-1:0]  BATCH_LAST = IDX_W'(BATCH_SIZE - 1);
  localparam logic [ADDR_W-1:0] BANK_OFFSET = ADDR_W'(BATCH_SIZE);

  localparam logic [WORD_W-1:0] POWER_LIMIT_RESET = 16'd200;
  localparam logic [WORD_W-1:0] SAMPLE_INTERVAL_RESET = 16'd20;
  localparam logic [WORD_W-1:0] PWM_MIN_RESET = 16'd1563;
  localparam logic [WORD_W-1:0] PWM_MAX_RESET = 16'd3125;
  localparam logic [WORD_W-1:0] DUTY_RESET = 16'd2344;

  localparam logic [7:0] CMD_LEN_ONE = 8'd1;
  localparam logic [7:0] CMD_UNLOCK  = 8'd0;
  localparam logic [7:0] CMD_LOCK    = 8'd1;

  typedef enum logic [1:0] {
    CFG_POWER_LIMIT     = 2'd0,
    CFG_SAMPLE_INTERVAL = 2'd1,
    CFG_PWM_MIN         = 2'd2,
    CFG_PWM_MAX         = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_CMD    = 2'd1,
    KIND_REPORT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STREAM_POWER    = 2'd0,
    STREAM_POSITION = 2'd1,
    STREAM_SENSE    = 2'd2
  } stream_t;

  typedef enum logic [1:0] {
    RES_STATUS = 2'd0,
    RES_POWER  = 2'd1,
    RES_SAMPLE = 2'd2
  } res_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EMIT,
    ST_BATCH,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic      load;
    logic      tick;
    logic      apply_cmd;
    logic      mark_seen;
    logic      rd_issue;
    logic      emit;
    res_kind_t emit_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] stream;
    logic       cmd_ok;
    logic       new_batch;
    logic       batch_last;
  } dp_stat_t;

endpackage

// ===== src/servo_lock_power_sampler_unit.sv =====
`timescale 1ns / 1ps
// Channel   Handshake              Ports
// request   start && !busy         in_kind .. in_report_stream
// result    out_valid (1 cycle)    out_result_kind .. out_last
// config    cfg_we                 cfg_index, cfg_wdata
//
// Tick and command requests pass through ST_DECODE and ST_EMIT before the registered
// result strobe; power, status-only and ignored requests emit from ST_DECODE directly.
// A new batch report streams BATCH_SIZE words on consecutive cycles, each read from
// the one-read-per-cycle sample RAM (registered read) and then the output register;
// the request holds busy through ST_DECODE, ST_BATCH and ST_DRAIN.
// Reset is synchronous on rst_n low; no clearing pass is needed.
// The receiver cannot stall: each result is valid for exactly one cycle.
module servo_lock_power_sampler_unit import slps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_kind,
  input  logic [7:0]        in_cmd_value,
  input  logic [7:0]        in_payload_length,
  input  logic              in_sample_ok,
  input  logic [WORD_W-1:0] in_sample_position,
  input  logic [WORD_W-1:0] in_sample_sense,
  input  logic [1:0]        in_report_stream,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [WORD_W-1:0] cfg_wdata,
  output logic              out_valid,
  output logic [1:0]        out_result_kind,
  output logic [WORD_W-1:0] out_duty_counts,
  output logic              out_power_on,
  output logic [WORD_W-1:0] out_report_word,
  output logic [WORD_W-1:0] out_batch_generation,
  output logic              out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  slps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  slps_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_kind              (in_kind),
    .in_cmd_value         (in_cmd_value),
    .in_payload_length    (in_payload_length),
    .in_sample_ok         (in_sample_ok),
    .in_sample_position   (in_sample_position),
    .in_sample_sense      (in_sample_sense),
    .in_report_stream     (in_report_stream),
    .out_valid            (out_valid),
    .out_result_kind      (out_result_kind),
    .out_duty_counts      (out_duty_counts),
    .out_power_on         (out_power_on),
    .out_report_word      (out_report_word),
    .out_batch_generation (out_batch_generation),
    .out_last             (out_last)
  );

`ifndef SYNTHESIS
  a_batch_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("batch words not contiguous");

  a_sample_needs_gen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RES_SAMPLE |-> out_batch_generation != '0)
    else $error("sample word without published batch");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != RES_SAMPLE |-> out_last)
    else $error("single result not marked last");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");
`endif

endmodule

// ===== src/slps_ram.sv =====
`timescale 1ns / 1ps
module slps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/slps_dp.sv =====
`timescale 1ns / 1ps
module slps_dp import slps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [WORD_W-1:0] cfg_wdata,
  input  logic [1:0]        in_kind,
  input  logic [7:0]        in_cmd_value,
  input  logic [7:0]        in_payload_length,
  input  logic              in_sample_ok,
  input  logic [WORD_W-1:0] in_sample_position,
  input  logic [WORD_W-1:0] in_sample_sense,
  input  logic [1:0]        in_report_stream,
  output logic              out_valid,
  output logic [1:0]        out_result_kind,
  output logic [WORD_W-1:0] out_duty_counts,
  output logic              out_power_on,
  output logic [WORD_W-1:0] out_report_word,
  output logic [WORD_W-1:0] out_batch_generation,
  output logic              out_last
);

  logic [WORD_W-1:0] limit_r, interval_r, min_r, max_r;

  logic [1:0]        kind_r, stream_r;
  logic [7:0]        cmd_value_r, len_r;
  logic              ok_r;
  logic [WORD_W-1:0] pos_r, sense_r;

  logic [TIME_WIDTH-1:0] time_r, time_nxt;
  logic [TIME_WIDTH-1:0] power_start_r, power_start_nxt;
  logic [TIME_WIDTH-1:0] sample_last_r, sample_last_nxt;
  logic                  powered_r, powered_nxt;
  logic [WORD_W-1:0]     duty_r, duty_nxt;
  logic [IDX_W-1:0]      fill_r, fill_nxt;
  logic                  bank_r, bank_nxt;
  logic [WORD_W-1:0]     gen_r, gen_nxt, gen_inc;
  logic [WORD_W-1:0]     pos_seen_r, pos_seen_nxt;
  logic [WORD_W-1:0]     sense_seen_r, sense_seen_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  rd_valid_r, rd_last_r;

  logic [TIME_WIDTH-1:0] time_inc, pwr_elapsed, smp_elapsed;
  logic                  pwr_expired, sample_due, store_en;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic [WORD_W-1:0]     pos_rdata, sense_rdata, seen_sel;

  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic [WORD_W-1:0] out_duty_r, out_word_r, out_gen_r;
  logic              out_power_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= POWER_LIMIT_RESET;
      interval_r <= SAMPLE_INTERVAL_RESET;
      min_r      <= PWM_MIN_RESET;
      max_r      <= PWM_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POWER_LIMIT:     limit_r    <= cfg_wdata;
        CFG_SAMPLE_INTERVAL: interval_r <= cfg_wdata;
        CFG_PWM_MIN:         min_r      <= cfg_wdata;
        CFG_PWM_MAX:         max_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r      <= in_kind;
      cmd_value_r <= in_cmd_value;
      len_r       <= in_payload_length;
      ok_r        <= in_sample_ok;
      pos_r       <= in_sample_position;
      sense_r     <= in_sample_sense;
      stream_r    <= in_report_stream;
    end
  end

  assign time_inc    = time_r + TIME_WIDTH'(1);
  assign pwr_elapsed = time_inc - power_start_r;
  assign smp_elapsed = time_inc - sample_last_r;
  assign pwr_expired = CMP_W'(pwr_elapsed) >= CMP_W'(limit_r);
  assign sample_due  = CMP_W'(smp_elapsed) >= CMP_W'(interval_r);
  assign store_en    = cmd.tick && sample_due && ok_r;
  assign gen_inc     = gen_r + WORD_W'(1);

  assign waddr = bank_r ? ADDR_W'(fill_r) : BANK_OFFSET + ADDR_W'(fill_r);
  assign raddr = bank_r ? BANK_OFFSET + ADDR_W'(idx_r) : ADDR_W'(idx_r);

  assign seen_sel = (stream_r == STREAM_POSITION) ? pos_seen_r : sense_seen_r;

  always_comb begin
    time_nxt        = time_r;
    powered_nxt     = powered_r;
    power_start_nxt = power_start_r;
    sample_last_nxt = sample_last_r;
    duty_nxt        = duty_r;
    fill_nxt        = fill_r;
    bank_nxt        = bank_r;
    gen_nxt         = gen_r;
    pos_seen_nxt    = pos_seen_r;
    sense_seen_nxt  = sense_seen_r;
    idx_nxt         = idx_r;
    if (cmd.tick) begin
      time_nxt = time_inc;
      if (powered_r && pwr_expired) begin
        powered_nxt = 1'b0;
      end
      if (sample_due) begin
        sample_last_nxt = time_inc;
      end
      if (store_en) begin
        if (fill_r == BATCH_LAST) begin
          fill_nxt = '0;
          bank_nxt = !bank_r;
          gen_nxt  = (gen_inc == '0) ? WORD_W'(1) : gen_inc;
        end else begin
          fill_nxt = fill_r + IDX_W'(1);
        end
      end
    end
    if (cmd.apply_cmd) begin
      if (cmd_value_r == CMD_LOCK) begin
        duty_nxt = min_r;
      end else begin
        duty_nxt = (max_r < min_r) ? min_r : max_r;
      end
      if (!powered_r) begin
        power_start_nxt = time_r;
        powered_nxt     = 1'b1;
      end
    end
    if (cmd.mark_seen) begin
      if (stream_r == STREAM_POSITION) begin
        pos_seen_nxt = gen_r;
      end else begin
        sense_seen_nxt = gen_r;
      end
    end
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.rd_issue && idx_r != BATCH_LAST) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r        <= '0;
      powered_r     <= 1'b0;
      power_start_r <= '0;
      sample_last_r <= '0;
      duty_r        <= DUTY_RESET;
      fill_r        <= '0;
      bank_r        <= 1'b0;
      gen_r         <= '0;
      pos_seen_r    <= '0;
      sense_seen_r  <= '0;
      idx_r         <= '0;
      rd_valid_r    <= 1'b0;
      rd_last_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      time_r        <= time_nxt;
      powered_r     <= powered_nxt;
      power_start_r <= power_start_nxt;
      sample_last_r <= sample_last_nxt;
      duty_r        <= duty_nxt;
      fill_r        <= fill_nxt;
      bank_r        <= bank_nxt;
      gen_r         <= gen_nxt;
      pos_seen_r    <= pos_seen_nxt;
      sense_seen_r  <= sense_seen_nxt;
      idx_r         <= idx_nxt;
      rd_valid_r    <= cmd.rd_issue;
      rd_last_r     <= cmd.rd_issue && (idx_r == BATCH_LAST);
      out_valid_r   <= rd_valid_r || cmd.emit;
    end
  end

  slps_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (store_en),
    .waddr (waddr),
    .wdata (pos_r),
    .raddr (raddr),
    .rdata (pos_rdata)
  );

  slps_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_sense_ram (
    .clk   (clk),
    .we    (store_en),
    .waddr (waddr),
    .wdata (sense_r),
    .raddr (raddr),
    .rdata (sense_rdata)
  );

  always_ff @(posedge clk) begin
    out_duty_r  <= duty_r;
    out_power_r <= powered_r;
    out_gen_r   <= gen_r;
    if (rd_valid_r) begin
      out_kind_r <= RES_SAMPLE;
      out_word_r <= (stream_r == STREAM_POSITION) ? pos_rdata : sense_rdata;
      out_last_r <= rd_last_r;
    end else begin
      out_kind_r <= cmd.emit_kind;
      out_word_r <= (cmd.emit_kind == RES_POWER) ? {{(WORD_W-1){1'b0}}, powered_r} : '0;
      out_last_r <= 1'b1;
    end
  end

  assign stat.kind       = kind_r;
  assign stat.stream     = stream_r;
  assign stat.cmd_ok     = (len_r == CMD_LEN_ONE) &&
                           (cmd_value_r == CMD_UNLOCK || cmd_value_r == CMD_LOCK);
  assign stat.new_batch  = (gen_r != '0) && (gen_r != seen_sel);
  assign stat.batch_last = (idx_r == BATCH_LAST);

  assign out_valid            = out_valid_r;
  assign out_result_kind      = out_kind_r;
  assign out_duty_counts      = out_duty_r;
  assign out_power_on         = out_power_r;
  assign out_report_word      = out_word_r;
  assign out_batch_generation = out_gen_r;
  assign out_last             = out_last_r;

endmodule

// ===== src/slps_ctrl.sv =====
`timescale 1ns / 1ps
module slps_ctrl import slps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.emit_kind = RES_STATUS;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.kind)
          KIND_TICK: begin
            cmd.tick  = 1'b1;
            state_nxt = ST_EMIT;
          end
          KIND_CMD: begin
            cmd.apply_cmd = stat.cmd_ok;
            state_nxt     = ST_EMIT;
          end
          KIND_REPORT: begin
            if (stat.stream == STREAM_POWER) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = RES_POWER;
              state_nxt     = ST_IDLE;
            end else if ((stat.stream inside {STREAM_POSITION, STREAM_SENSE}) &&
                         stat.new_batch) begin
              cmd.mark_seen = 1'b1;
              state_nxt     = ST_BATCH;
            end else begin
              cmd.emit  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            cmd.emit  = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_BATCH: begin
        cmd.rd_issue = 1'b1;
        if (stat.batch_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule
